FILE: hdl/prw_pkg.sv
// shared types and constants of the packet reorder window
package prw_pkg;

  localparam int WINDOW = 64;
  localparam int NSLOTS = 64;
  localparam int SLOT_W = 6;
  localparam int SEQ_W = 16;
  localparam int HANDLE_W = 32;
  localparam int ACK_W = 64;
  localparam int STATUS_W = 3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic FUNC_INIT = 1'b0;

  localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HELD      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUTWIN    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CONFLICT  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_INIT      = 3'd5;

  typedef struct packed {
    logic                is_init;
    logic [SEQ_W-1:0]    seqno;
    logic [HANDLE_W-1:0] handle;
    logic [SLOT_W-1:0]   slot;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hdl/prw_front.sv
// intake stage: takes input transfers and decodes them into commands
module prw_front import prw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [SEQ_W-1:0]    seqno,
  input  logic [HANDLE_W-1:0] packet_handle,
  input  q_status_t           qstat,
  output logic                push,
  output cmd_t                push_cmd
);

  logic hold;
  logic take;

  assign in_stall = hold && qstat.full;
  assign take     = in_valid && !in_stall;
  assign push     = hold && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (take) begin
      hold <= 1'b1;
    end else if (push) begin
      hold <= 1'b0;
    end
  end

  // slot index is the low sequence bits whatever the window size
  always_ff @(posedge clk) begin
    if (take) begin
      push_cmd.is_init <= (func == FUNC_INIT);
      push_cmd.seqno   <= seqno;
      push_cmd.handle  <= packet_handle;
      push_cmd.slot    <= seqno[SLOT_W-1:0];
    end
  end

endmodule

FILE: hdl/prw_queue.sv
// short command queue between intake and release engine
module prw_queue import prw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t qstat
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: hdl/prw_engine.sv
// release engine: window state, slot store, in-order release walk, output register
module prw_engine import prw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                q_cmd,
  input  q_status_t           qstat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [SEQ_W-1:0]    out_seqno,
  output logic [HANDLE_W-1:0] out_handle,
  output logic                last,
  output logic [ACK_W-1:0]    ack_mask_out,
  output logic [SEQ_W-1:0]    ack_base_out
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DUP  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [NSLOTS-1:0]   slot_valid;
  logic [HANDLE_W-1:0] slot_mem [NSLOTS];
  logic [HANDLE_W-1:0] rd_data;
  logic [SLOT_W-1:0]   rd_addr;
  logic                rd_en;
  logic [SEQ_W-1:0]    next_expected;
  logic [SEQ_W-1:0]    next_expected_next;
  logic [SEQ_W-1:0]    ack_base;
  logic [SEQ_W-1:0]    ack_base_next;
  logic [ACK_W-1:0]    ack_bits;
  logic [ACK_W-1:0]    ack_bits_next;
  cmd_t                cmd;
  logic [SEQ_W-1:0]    del_seq;

  logic                out_free;
  logic [SEQ_W-1:0]    seq_off;
  logic                in_win;
  logic [SLOT_W-1:0]   ack_pos;
  logic [SLOT_W-1:0]   pos;
  logic                pos_valid;
  logic                store;
  logic                release_slot;
  logic                emit;
  logic [STATUS_W-1:0] e_status;
  logic [SEQ_W-1:0]    e_seq;
  logic [HANDLE_W-1:0] e_handle;
  logic                e_last;

  assign out_free  = !out_valid || !out_stall;
  assign pop       = (state == S_IDLE) && !qstat.empty && out_free;
  assign seq_off   = q_cmd.seqno - next_expected;
  assign in_win    = (seq_off < SEQ_W'(WINDOW));
  assign ack_pos   = q_cmd.slot - ack_base[SLOT_W-1:0];
  assign pos       = next_expected[SLOT_W-1:0];
  assign pos_valid = slot_valid[pos];
  assign rd_en     = (state == S_IDLE) || (state == S_WALK);
  assign rd_addr   = (state == S_IDLE) ? q_cmd.slot : pos;

  always_comb begin
    state_next         = state;
    next_expected_next = next_expected;
    ack_base_next      = ack_base;
    ack_bits_next      = ack_bits;
    store              = 1'b0;
    release_slot       = 1'b0;
    emit               = 1'b0;
    e_status           = ST_HELD;
    e_seq              = cmd.seqno;
    e_handle           = cmd.handle;
    e_last             = 1'b1;
    case (state)
      S_IDLE: begin
        if (pop) begin
          if (q_cmd.is_init) begin
            next_expected_next = q_cmd.seqno;
            ack_base_next      = q_cmd.seqno - 16'd1;
            ack_bits_next      = ACK_W'(1);
            emit               = 1'b1;
            e_status           = ST_INIT;
            e_seq              = q_cmd.seqno;
            e_handle           = '0;
          end else if (!in_win) begin
            emit     = 1'b1;
            e_status = ST_OUTWIN;
            e_seq    = q_cmd.seqno;
            e_handle = q_cmd.handle;
          end else if (slot_valid[q_cmd.slot]) begin
            // stored handle comes out of the slot memory next cycle
            state_next = S_DUP;
          end else begin
            store         = 1'b1;
            ack_bits_next = ack_bits | (ACK_W'(1) << ack_pos);
            state_next    = S_WALK;
          end
        end
      end
      S_DUP: begin
        if (out_free) begin
          emit       = 1'b1;
          e_status   = (rd_data == cmd.handle) ? ST_DUP : ST_CONFLICT;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (pos_valid) begin
          release_slot       = 1'b1;
          next_expected_next = next_expected + 16'd1;
          state_next         = S_EMIT;
        end else if (out_free) begin
          // nothing releasable right after the store
          emit       = 1'b1;
          e_status   = ST_HELD;
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          e_status   = ST_DELIVERED;
          e_seq      = del_seq;
          e_handle   = rd_data;
          e_last     = !pos_valid;
          state_next = pos_valid ? S_WALK : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_valid    <= '0;
      next_expected <= '0;
      ack_base      <= '0;
      ack_bits      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      next_expected <= next_expected_next;
      ack_base      <= ack_base_next;
      ack_bits      <= ack_bits_next;
      if (store) begin
        slot_valid[q_cmd.slot] <= 1'b1;
      end
      if (release_slot) begin
        slot_valid[pos] <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_cmd;
    end
    if (release_slot) begin
      del_seq <= next_expected;
    end
    if (emit) begin
      status       <= e_status;
      out_seqno    <= e_seq;
      out_handle   <= e_handle;
      last         <= e_last;
      ack_mask_out <= ack_bits_next;
      ack_base_out <= ack_base_next;
    end
  end

  // slot handle memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (store) begin
      slot_mem[q_cmd.slot] <= q_cmd.handle;
    end
    if (rd_en) begin
      rd_data <= slot_mem[rd_addr];
    end
  end

  a_emit_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (del_seq + 16'd1 == next_expected))
    else $error("delivered seqno out of step with next expected");

  a_emit_freed: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> !slot_valid[del_seq[SLOT_W-1:0]])
    else $error("delivered slot still marked valid");

  a_store_walk: assert property (@(posedge clk) disable iff (rst)
    store |=> (state == S_WALK) && slot_valid[$past(q_cmd.slot)])
    else $error("store not followed by release walk");

  a_dup_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUP) |-> slot_valid[cmd.slot])
    else $error("duplicate check on a free slot");

endmodule

FILE: hdl/packet_reorder_window_top.sv
// top level of the packet reorder window
//
// receive-side reorder window for 16-bit sequence-numbered packets
// input channel: in_valid/in_stall, transfer carries func, seqno, packet_handle
//   func 0 re-arms the window at seqno, func 1 is a data packet
// output channel: out_valid/out_stall, one transfer per result, last marks
//   the final result of an input item; ack mask/base reflect the whole item
// an intake register feeds a two-entry command queue; the release engine
//   behind it owns all window state and one output register
// path when idle: the intake register, the queue, the engine, then the output
//   register; after S_IDLE a duplicate passes S_DUP (slot memory read), a held
//   item S_WALK, and in-order deliveries S_WALK then S_EMIT for each release
//   (one memory read per release); init and out of window need S_IDLE only
// a new input is taken while the engine walks until the queue and intake are full
// reset clears all slot valid bits, next expected, ack base and ack mask at
//   once; the slot handle memory is not cleared and needs no clearing pass
// when the receiver stalls the result holds, the engine waits, the queue
//   fills and in_stall rises
module packet_reorder_window_top import prw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [SEQ_W-1:0]    seqno,
  input  logic [HANDLE_W-1:0] packet_handle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [SEQ_W-1:0]    out_seqno,
  output logic [HANDLE_W-1:0] out_handle,
  output logic                last,
  output logic [ACK_W-1:0]    ack_mask_out,
  output logic [SEQ_W-1:0]    ack_base_out
);

  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      q_cmd;
  q_status_t qstat;

  // intake register and decode
  prw_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .seqno         (seqno),
    .packet_handle (packet_handle),
    .qstat         (qstat),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  // decouples intake from the release walk
  prw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_cmd),
    .qstat    (qstat)
  );

  // window state, classification and in-order release
  prw_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .q_cmd        (q_cmd),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_seqno    (out_seqno),
    .out_handle   (out_handle),
    .last         (last),
    .ack_mask_out (ack_mask_out),
    .ack_base_out (ack_base_out)
  );

endmodule
